### src/lkvt_pkg.sv
package lkvt_pkg;

  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int KIND_W    = 2;
  localparam int STAT_W    = 2;
  localparam int CAP_W     = 5;
  localparam int CNT_OUT_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // operation codes carried in the kind field
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  // one table entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } kv_t;

  // one finished result
  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [VAL_W-1:0]     found;
    logic [CNT_OUT_W-1:0] count;
  } res_t;

endpackage

### src/linear_key_value_table_top.sv
// Operation: every insert, lookup or delete scans the stored entries in order, and a delete
//   hit then runs a shift pass that moves the later entries down; an unused kind goes straight
//   to a result. Only one item is in flight at a time; in_tready returns once the previous
//   result has been taken into the output register.
// Reset: rst_n synchronous, active low; clears the entry count and the output valid flag
//   and sets the capacity to 16. Entry contents are not cleared; no clearing pass.
module linear_key_value_table_top #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // key [31:0], value_word [63:32]
  input  logic [1:0]  in_tuser,   // kind [1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // found_value [31:0], entry_count [36:32], zero [39:37]
  output logic [1:0]  out_tuser,  // status [1:0]
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data    // capacity_limit [4:0]
);
  import lkvt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CAP_W-1:0] cap_r;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             out_valid_r;
  res_t             out_res_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  kv_t           wr_kv;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  kv_t           rd_kv;

  // capacity register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  lkvt_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_kind  (in_tuser),
    .req_key   (in_tdata[31:0]),
    .req_val   (in_tdata[63:32]),
    .cap       (cap_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_kv     (wr_kv),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_kv     (rd_kv)
  );

  lkvt_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_kv   (wr_kv),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_kv   (rd_kv)
  );

  // output register: take a result when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {3'b000, out_res_r.count, out_res_r.found};

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_tready)
    else $error("input ready while a result is pending");

  // a real operation passes through the scan state before its result
  a_scan_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == KIND_INSERT || in_tuser == KIND_LOOKUP ||
     in_tuser == KIND_DELETE)) |=> !res_valid)
    else $error("result without a scan");

  // count never exceeds the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (32'(res.count) <= 32'(DEPTH)))
    else $error("entry count above depth");

  // a returned value only comes with a successful status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.found != '0) |-> (res.status == STAT_OK))
    else $error("value returned on a failed operation");

endmodule

### src/lkvt_store.sv
module lkvt_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  lkvt_pkg::kv_t     wr_kv,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output lkvt_pkg::kv_t     rd_kv
);
  import lkvt_pkg::*;

  kv_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_kv;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_kv <= mem[rd_addr];
    end
  end

endmodule

### src/lkvt_ctrl.sv
module lkvt_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request side
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [lkvt_pkg::KIND_W-1:0]   req_kind,
  input  logic [lkvt_pkg::KEY_W-1:0]    req_key,
  input  logic [lkvt_pkg::VAL_W-1:0]    req_val,
  input  logic [lkvt_pkg::CAP_W-1:0]    cap,
  // result side
  output logic                          res_valid,
  input  logic                          res_ready,
  output lkvt_pkg::res_t                res,
  // entry store
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output lkvt_pkg::kv_t                 wr_kv,
  output logic                          rd_en,
  output logic [AW-1:0]                 rd_addr,
  input  lkvt_pkg::kv_t                 rd_kv
);
  import lkvt_pkg::*;

  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  state_t            state_r,  state_nxt;
  logic [KIND_W-1:0] kind_r,   kind_nxt;
  logic [KEY_W-1:0]  key_r,    key_nxt;
  logic [VAL_W-1:0]  val_r,    val_nxt;
  logic [CW-1:0]     count_r,  count_nxt;
  logic [CW-1:0]     issue_r,  issue_nxt;
  logic              pend_r,   pend_nxt;
  logic [AW-1:0]     pidx_r,   pidx_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [VAL_W-1:0]  found_r,  found_nxt;

  logic [LW-1:0] cap_ext;
  logic [LW-1:0] lim;
  logic [LW-1:0] cnt_ext;
  logic          at_limit;
  logic          hit;
  logic          more;

  // effective capacity saturates at the table depth
  assign cap_ext  = LW'(cap);
  assign lim      = (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
  assign cnt_ext  = LW'(count_r);
  assign at_limit = (cnt_ext >= lim);

  // compare unit: returned entry against the held key
  assign hit  = pend_r && (rd_kv.key == key_r);
  assign more = (issue_r < count_r);

  assign req_ready  = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);
  assign res.status = status_r;
  assign res.found  = found_r;
  assign res.count  = cnt_ext[CNT_OUT_W-1:0];

  // state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    issue_r  <= issue_nxt;
    pidx_r   <= pidx_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    count_nxt  = count_r;
    issue_nxt  = issue_r;
    pend_nxt   = pend_r;
    pidx_nxt   = pidx_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    wr_en      = 1'b0;
    wr_addr    = pidx_r;
    wr_kv.key  = key_r;
    wr_kv.value = val_r;
    rd_en      = 1'b0;
    rd_addr    = issue_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          kind_nxt   = req_kind;
          key_nxt    = req_key;
          val_nxt    = req_val;
          issue_nxt  = '0;
          pend_nxt   = 1'b0;
          status_nxt = STAT_ABSENT;
          found_nxt  = '0;
          if (req_kind == KIND_INSERT || req_kind == KIND_LOOKUP ||
              req_kind == KIND_DELETE) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          unique case (kind_r)
            KIND_INSERT: begin
              wr_en      = 1'b1;
              wr_addr    = pidx_r;
              status_nxt = STAT_OK;
              state_nxt  = S_DONE;
            end
            KIND_LOOKUP: begin
              found_nxt  = rd_kv.value;
              status_nxt = STAT_OK;
              state_nxt  = S_DONE;
            end
            KIND_DELETE: begin
              // restart reads just past the removed entry
              issue_nxt = CW'(pidx_r) + CW'(1);
              pend_nxt  = 1'b0;
              state_nxt = S_SHIFT;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end else if (!pend_r && !more) begin
          // key absent
          if (kind_r == KIND_INSERT) begin
            if (at_limit) begin
              status_nxt = STAT_FULL;
            end else begin
              wr_en      = 1'b1;
              wr_addr    = count_r[AW-1:0];
              count_nxt  = count_r + CW'(1);
              status_nxt = STAT_OK;
            end
          end
          state_nxt = S_DONE;
        end else begin
          // issue the next entry read
          pend_nxt = more;
          pidx_nxt = issue_r[AW-1:0];
          if (more) begin
            rd_en     = 1'b1;
            issue_nxt = issue_r + CW'(1);
          end
        end
      end

      S_SHIFT: begin
        // move the returned entry down one place
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pidx_r - AW'(1);
          wr_kv   = rd_kv;
        end
        if (!pend_r && !more) begin
          count_nxt  = count_r - CW'(1);
          status_nxt = STAT_OK;
          state_nxt  = S_DONE;
        end else begin
          pend_nxt = more;
          pidx_nxt = issue_r[AW-1:0];
          if (more) begin
            rd_en     = 1'b1;
            issue_nxt = issue_r + CW'(1);
          end
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
